### rtl/tds_pkg.sv
package tds_pkg;

  localparam int unsigned QueueDepth = 64;
  localparam int unsigned SlotW      = 6;
  localparam int unsigned CountW     = 7;

  localparam logic [31:0] PrecisionReset = 32'd12884902;
  localparam logic [15:0] MaxLengthReset = 16'd1000;

  localparam logic [1:0] CmdPacket = 2'd0;
  localparam logic [1:0] CmdTick   = 2'd1;
  localparam logic [1:0] CmdClear  = 2'd2;
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam logic [2:0] RouteOnTime    = 3'd0;
  localparam logic [2:0] RouteMissed    = 3'd1;
  localparam logic [2:0] RouteImmediate = 3'd2;
  localparam logic [2:0] RouteFull      = 3'd3;
  localparam logic [2:0] RouteLong      = 3'd4;
  localparam logic [2:0] RouteQueued    = 3'd5;

  localparam logic [0:0] RegPrecision = 1'd0;
  localparam logic [0:0] RegMaxLength = 1'd1;

  typedef enum logic [3:0] {
    StIdle,
    StDecide,
    StFind,
    StWrite,
    StScan,
    StScanWait,
    StRelease,
    StSummary,
    StOut
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic decide;
    logic find_step;
    logic write_slot;
    logic scan_start;
    logic scan_step;
    logic release_slot;
    logic clear_all;
    logic out_load;
    logic out_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       arrival_direct;
    logic       slot_is_free;
    logic       scan_done;
    logic       scan_found;
    logic       best_due;
  } dp_stat_t;

endpackage

### rtl/tds_ram.sv
module tds_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tds_datapath.sv
module tds_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tds_pkg::dp_cmd_t       cmd_i,
  output tds_pkg::dp_stat_t      stat_o,
  input  logic [63:0]            packet_time_i,
  input  logic [15:0]            packet_length_i,
  input  logic [15:0]            packet_handle_i,
  input  logic [63:0]            current_time_i,
  input  logic [31:0]            precision_i,
  input  logic [15:0]            max_length_i,
  output logic [2:0]             route_o,
  output logic [15:0]            out_handle_o,
  output logic [15:0]            out_length_o,
  output logic [5:0]             slot_used_o,
  output logic                   last_of_run_o,
  output logic [6:0]             pending_count_o,
  output logic [63:0]            next_due_o
);

  localparam int unsigned Depth = tds_pkg::QueueDepth;
  localparam int unsigned SW    = tds_pkg::SlotW;

  logic [63:0] time_q, now_q;
  logic [15:0] len_q, handle_q;
  logic [64:0] dl_sum;
  logic [63:0] dl_d, dl_q;
  logic [2:0]  route_q;
  logic        direct_q;

  logic [Depth-1:0] free_q;
  logic [SW-1:0]    search_q, ptr_q, best_q;
  logic [6:0]       count_q;
  logic [63:0]      best_time_q;
  logic             best_valid_q;
  logic [SW:0]      scan_cnt_q;
  logic [SW-1:0]    scan_addr_q;
  logic             scan_rd_q;

  logic [2:0]  o_route_q;
  logic [15:0] o_handle_q, o_length_q;
  logic [5:0]  o_slot_q;
  logic        o_last_q;

  logic [SW-1:0] rd_addr;
  logic [SW-1:0] wr_addr;
  logic [63:0]   rd_time;
  logic [15:0]   rd_handle, rd_length;
  logic          we;

  assign dl_sum = {1'b0, current_time_i} + {33'd0, precision_i};
  assign dl_d   = dl_sum[64] ? '1 : dl_sum[63:0];

  // Arrival classification, registered so the slot search starts clean.
  logic [2:0] route_d;
  logic       direct_d;
  always_comb begin
    direct_d = 1'b1;
    priority if (count_q >= 7'(Depth)) begin
      route_d = tds_pkg::RouteFull;
    end else if (len_q >= max_length_i) begin
      route_d = tds_pkg::RouteLong;
    end else if (time_q == 64'd1) begin
      route_d = tds_pkg::RouteImmediate;
    end else if (time_q < now_q) begin
      route_d = tds_pkg::RouteMissed;
    end else if (time_q <= dl_q) begin
      route_d = tds_pkg::RouteOnTime;
    end else begin
      route_d  = tds_pkg::RouteQueued;
      direct_d = 1'b0;
    end
  end

  assign we      = cmd_i.write_slot;
  assign wr_addr = ptr_q;
  assign rd_addr = cmd_i.release_slot ? best_q : scan_addr_q;

  tds_ram #(.Width(64), .Depth(Depth)) u_time (
    .clk_i, .we_i(we), .waddr_i(wr_addr), .wdata_i(time_q),
    .raddr_i(rd_addr), .rdata_o(rd_time)
  );
  tds_ram #(.Width(16), .Depth(Depth)) u_handle (
    .clk_i, .we_i(we), .waddr_i(wr_addr), .wdata_i(handle_q),
    .raddr_i(best_q), .rdata_o(rd_handle)
  );
  tds_ram #(.Width(16), .Depth(Depth)) u_length (
    .clk_i, .we_i(we), .waddr_i(wr_addr), .wdata_i(len_q),
    .raddr_i(best_q), .rdata_o(rd_length)
  );

  function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] v);
    wrap_inc = (v == SW'(Depth - 1)) ? '0 : v + SW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      time_q   <= packet_time_i;
      now_q    <= current_time_i;
      len_q    <= packet_length_i;
      handle_q <= packet_handle_i;
      dl_q     <= dl_d;
    end
    if (cmd_i.decide) begin
      route_q  <= route_d;
      direct_q <= direct_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q       <= '1;
      search_q     <= '0;
      ptr_q        <= '0;
      best_q       <= '0;
      count_q      <= '0;
      best_time_q  <= '0;
      best_valid_q <= 1'b0;
      scan_cnt_q   <= '0;
      scan_addr_q  <= '0;
      scan_rd_q    <= 1'b0;
      o_route_q    <= '0;
      o_handle_q   <= '0;
      o_length_q   <= '0;
      o_slot_q     <= '0;
      o_last_q     <= 1'b0;
    end else begin
      if (cmd_i.decide) begin
        ptr_q <= search_q;
      end
      if (cmd_i.find_step) begin
        ptr_q <= wrap_inc(ptr_q);
      end
      if (cmd_i.write_slot) begin
        free_q[ptr_q] <= 1'b0;
        search_q      <= wrap_inc(ptr_q);
        count_q       <= count_q + 7'd1;
      end
      if (cmd_i.clear_all) begin
        free_q  <= '1;
        count_q <= '0;
      end
      // Minimum scan: one RAM read issued per cycle, compared in the next cycle.
      if (cmd_i.scan_start) begin
        scan_cnt_q   <= '0;
        scan_addr_q  <= '0;
        scan_rd_q    <= 1'b0;
        best_valid_q <= 1'b0;
        best_time_q  <= '0;
      end else if (cmd_i.scan_step) begin
        if (scan_cnt_q != (SW+1)'(Depth)) begin
          scan_addr_q <= scan_addr_q + SW'(1);
          scan_cnt_q  <= scan_cnt_q + (SW+1)'(1);
        end
        scan_rd_q <= (scan_cnt_q != (SW+1)'(Depth));
        if (scan_rd_q && !free_q[scan_addr_q - SW'(1)] &&
            (!best_valid_q || rd_time < best_time_q)) begin
          best_valid_q <= 1'b1;
          best_time_q  <= rd_time;
          best_q       <= scan_addr_q - SW'(1);
        end
      end
      if (cmd_i.release_slot) begin
        free_q[best_q] <= 1'b1;
        search_q       <= best_q;
        count_q        <= count_q - 7'd1;
      end
      // A release captures its slot contents here; whether it ends the run
      // is known only after the rescan, which then raises out_last.
      if (cmd_i.out_load) begin
        if (cmd_i.release_slot) begin
          o_route_q  <= tds_pkg::RouteOnTime;
          o_handle_q <= rd_handle;
          o_length_q <= rd_length;
          o_slot_q   <= 6'(best_q);
        end else begin
          o_route_q  <= route_q;
          o_handle_q <= handle_q;
          o_length_q <= len_q;
          o_slot_q   <= (route_q == tds_pkg::RouteQueued) ? 6'(ptr_q) : 6'd0;
        end
      end
      if (cmd_i.out_last) begin
        o_last_q <= 1'b1;
      end else if (cmd_i.out_load) begin
        o_last_q <= 1'b0;
      end
    end
  end

  assign stat_o.arrival_direct = direct_q;
  assign stat_o.slot_is_free   = free_q[ptr_q];
  assign stat_o.scan_done      = (scan_cnt_q == (SW+1)'(Depth)) && !scan_rd_q;
  assign stat_o.scan_found     = best_valid_q;
  assign stat_o.best_due       = best_valid_q && (best_time_q <= dl_q);

  assign route_o         = o_route_q;
  assign out_handle_o    = o_handle_q;
  assign out_length_o    = o_length_q;
  assign slot_used_o     = o_slot_q;
  assign last_of_run_o   = o_last_q;
  assign pending_count_o = count_q;
  assign next_due_o      = best_valid_q ? best_time_q : 64'd0;

endmodule

### rtl/tds_ctrl.sv
module tds_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tds_pkg::dp_cmd_t  dp_cmd_o,
  input  tds_pkg::dp_stat_t dp_stat_i
);

  tds_pkg::state_e state_q, state_d;
  logic       tick_q, tick_d;
  logic       rel_q, rel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tds_pkg::StIdle;
      tick_q  <= 1'b0;
      rel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      tick_q  <= tick_d;
      rel_q   <= rel_d;
    end
  end

  // A tick runs scan, then release and rescan for every due entry; the rescan
  // refreshes next_due and tells whether the held release is the last one.
  // An arrival also rescans so next_due reflects the new entry.
  always_comb begin
    state_d     = state_q;
    tick_d      = tick_q;
    rel_d       = rel_q;
    dp_cmd_o    = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      tds_pkg::StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          dp_cmd_o.latch_in = 1'b1;
          unique case (cmd_i)
            tds_pkg::CmdPacket: begin
              tick_d  = 1'b0;
              rel_d   = 1'b0;
              state_d = tds_pkg::StDecide;
            end
            tds_pkg::CmdTick: begin
              tick_d  = 1'b1;
              rel_d   = 1'b0;
              state_d = tds_pkg::StScan;
            end
            tds_pkg::CmdClear: begin
              dp_cmd_o.clear_all = 1'b1;
              state_d = tds_pkg::StIdle;
            end
            default: state_d = tds_pkg::StIdle;
          endcase
        end
      end
      tds_pkg::StDecide: begin
        dp_cmd_o.decide = 1'b1;
        state_d = tds_pkg::StFind;
      end
      tds_pkg::StFind: begin
        if (dp_stat_i.arrival_direct) begin
          state_d = tds_pkg::StScan;
        end else if (dp_stat_i.slot_is_free) begin
          state_d = tds_pkg::StWrite;
        end else begin
          dp_cmd_o.find_step = 1'b1;
        end
      end
      tds_pkg::StWrite: begin
        dp_cmd_o.write_slot = 1'b1;
        state_d = tds_pkg::StScan;
      end
      tds_pkg::StScan: begin
        dp_cmd_o.scan_start = 1'b1;
        state_d = tds_pkg::StScanWait;
      end
      tds_pkg::StScanWait: begin
        dp_cmd_o.scan_step = 1'b1;
        if (dp_stat_i.scan_done) begin
          dp_cmd_o.scan_step = 1'b0;
          if (!tick_q) begin
            state_d = tds_pkg::StSummary;
          end else if (rel_q) begin
            if (!dp_stat_i.best_due) begin
              dp_cmd_o.out_last = 1'b1;
            end
            state_d = tds_pkg::StOut;
          end else if (dp_stat_i.best_due) begin
            state_d = tds_pkg::StRelease;
          end else begin
            state_d = tds_pkg::StIdle;
          end
        end
      end
      tds_pkg::StRelease: begin
        // Output register is free here: results wait in StOut otherwise.
        dp_cmd_o.release_slot = 1'b1;
        dp_cmd_o.out_load     = 1'b1;
        rel_d   = 1'b1;
        state_d = tds_pkg::StScan;
      end
      tds_pkg::StSummary: begin
        // An arrival always gives exactly one result, which closes its run.
        dp_cmd_o.out_load = 1'b1;
        dp_cmd_o.out_last = 1'b1;
        state_d = tds_pkg::StOut;
      end
      tds_pkg::StOut: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (tick_q && dp_stat_i.best_due) begin
            state_d = tds_pkg::StRelease;
          end else begin
            state_d = tds_pkg::StIdle;
          end
        end
      end
      default: state_d = tds_pkg::StIdle;
    endcase
  end

endmodule

### rtl/timetag_deadline_scheduler_core.sv
// Channel  | valid      | stall       | payload
// input    | in_valid_i | in_stall_o  | cmd_i, packet_time_i, packet_length_i, ...
// output   | out_valid_o| out_stall_i | route_o, out_handle_o, ..., next_due_o
// config   | psel/penable/pwrite | pready | paddr, pwdata, prdata
// An arrival's time grows with every occupied slot skipped in the slot search;
// its bulk is the 64-entry minimum scan over the due-time RAM read port.
// A tick costs one scan per released item plus one final scan.
// Reset clears the slot map, count and search start; stores need no clearing.
// A stalled result holds the block until it is taken.
module timetag_deadline_scheduler_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [63:0] packet_time_i,
  input  logic [15:0] packet_length_i,
  input  logic [15:0] packet_handle_i,
  input  logic [63:0] current_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  route_o,
  output logic [15:0] out_handle_o,
  output logic [15:0] out_length_o,
  output logic [5:0]  slot_used_o,
  output logic        last_of_run_o,
  output logic [6:0]  pending_count_o,
  output logic [63:0] next_due_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] prec_q;
  logic [15:0] maxlen_q;
  tds_pkg::dp_cmd_t  dp_cmd;
  tds_pkg::dp_stat_t dp_stat;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prec_q   <= tds_pkg::PrecisionReset;
      maxlen_q <= tds_pkg::MaxLengthReset;
    end else if (psel && penable && pwrite) begin
      if (paddr[1:0] == 2'd0) begin
        unique case (paddr[2:2])
          tds_pkg::RegPrecision: prec_q   <= pwdata;
          tds_pkg::RegMaxLength: maxlen_q <= pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (paddr[2:2])
      tds_pkg::RegPrecision: prdata = prec_q;
      tds_pkg::RegMaxLength: prdata = {16'd0, maxlen_q};
      default:               prdata = '0;
    endcase
  end

  tds_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i,
    .out_valid_o, .out_stall_i, .dp_cmd_o(dp_cmd), .dp_stat_i(dp_stat)
  );

  tds_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(dp_cmd), .stat_o(dp_stat),
    .packet_time_i, .packet_length_i, .packet_handle_i, .current_time_i,
    .precision_i(prec_q), .max_length_i(maxlen_q),
    .route_o, .out_handle_o, .out_length_o, .slot_used_o, .last_of_run_o,
    .pending_count_o, .next_due_o
  );

endmodule
